// ----- rtl/vpaf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpaf_pkg
// Types, codes and helpers shared by the packet acceptance filter.
// ----------------------------------------------------------------------------
package vpaf_pkg;

   // event codes reported with each result beat
   typedef enum logic [2:0] {
      EV_NEW_SESSION = 3'd0,
      EV_TARGET      = 3'd1,
      EV_NO_TARGET   = 3'd2,
      EV_SEMANTIC    = 3'd3,
      EV_FIELD       = 3'd4,
      EV_DUPLICATE   = 3'd5,
      EV_OLD         = 3'd6
   } event_code_type;

   // counter slots
   localparam int NUM_COUNTERS = 8;
   localparam logic [2:0] CNT_ACCEPTED  = 3'd0;
   localparam logic [2:0] CNT_TARGET    = 3'd1;
   localparam logic [2:0] CNT_NO_TARGET = 3'd2;
   localparam logic [2:0] CNT_SEMANTIC  = 3'd3;
   localparam logic [2:0] CNT_FIELD     = 3'd4;
   localparam logic [2:0] CNT_DUPLICATE = 3'd5;
   localparam logic [2:0] CNT_OLD       = 3'd6;
   localparam logic [2:0] CNT_SESSION   = 3'd7;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_POSITION_LIMIT = 1'b0;
   localparam logic REG_SPEED_LIMIT    = 1'b1;
   localparam logic [15:0] POSITION_LIMIT_RESET = 16'd500;
   localparam logic [15:0] SPEED_LIMIT_RESET    = 16'd2000;

   typedef logic [31:0] counter_type;
   typedef counter_type [NUM_COUNTERS-1:0] counter_array_type;

   typedef struct packed {
      logic               target_seen;
      logic               measured_flag;
      logic [15:0]        seq_number;
      logic [31:0]        source_time_ms;
      logic signed [15:0] ball_pos_mm;
      logic signed [15:0] predicted_mm;
      logic signed [15:0] ball_vel_mm_s;
   } req_beat_type;

   typedef struct packed {
      logic              session_started;
      logic              sequence_started;
      logic [31:0]       cur_session;
      logic [15:0]       last_seq;
      logic [31:0]       last_source_time;
      counter_array_type counters;
   } filter_state_type;

   typedef struct packed {
      logic [15:0] position_limit_mm;
      logic [15:0] speed_limit_mm_s;
   } limits_type;

   typedef struct packed {
      event_code_type     event_code;
      logic               accepted;
      logic [31:0]        session_number;
      logic signed [15:0] safe_predicted_mm;
      counter_array_type  counters;
   } rsp_beat_type;

   // magnitude of a 16-bit two's complement value; -32768 gives 32768
   function automatic logic [16:0] mag16(input logic [15:0] v);
      logic [16:0] ext;
      ext = {v[15], v};
      return ext[16] ? (~ext + 17'd1) : ext;
   endfunction

endpackage

// ----- rtl/vpaf_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpaf channels
// Valid/ready channel interfaces for packet beats and result beats.
// ----------------------------------------------------------------------------
interface vpaf_req_if;
   logic               valid;
   logic               ready;
   logic               target_seen;
   logic               measured_flag;
   logic [15:0]        seq_number;
   logic [31:0]        source_time_ms;
   logic signed [15:0] ball_pos_mm;
   logic signed [15:0] predicted_mm;
   logic signed [15:0] ball_vel_mm_s;

   modport source (
      output valid, target_seen, measured_flag, seq_number, source_time_ms,
             ball_pos_mm, predicted_mm, ball_vel_mm_s,
      input  ready
   );
   modport sink (
      input  valid, target_seen, measured_flag, seq_number, source_time_ms,
             ball_pos_mm, predicted_mm, ball_vel_mm_s,
      output ready
   );
endinterface

interface vpaf_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         event_code;
   logic               accepted;
   logic [31:0]        session_number;
   logic signed [15:0] safe_predicted_mm;
   logic [31:0]        accepted_total;
   logic [31:0]        target_total;
   logic [31:0]        no_target_total;
   logic [31:0]        semantic_error_total;
   logic [31:0]        field_error_total;
   logic [31:0]        duplicate_total;
   logic [31:0]        old_sequence_total;
   logic [31:0]        session_change_total;

   modport source (
      output valid, event_code, accepted, session_number, safe_predicted_mm,
             accepted_total, target_total, no_target_total,
             semantic_error_total, field_error_total, duplicate_total,
             old_sequence_total, session_change_total,
      input  ready
   );
   modport sink (
      input  valid, event_code, accepted, session_number, safe_predicted_mm,
             accepted_total, target_total, no_target_total,
             semantic_error_total, field_error_total, duplicate_total,
             old_sequence_total, session_change_total,
      output ready
   );
endinterface

// ----- rtl/vision_packet_acceptance_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vision_packet_acceptance_filter
// Position packet acceptance filter with session tracking and event counters.
// ----------------------------------------------------------------------------
// Takes one parsed position packet per req beat and returns exactly one rsp
// beat for it, in order: an event code, the accepted flag, the session id, a
// sanitized predicted position and the eight wrapping event counters as they
// stand after that packet. Throughput is one packet per clock while rsp
// beats are taken; each packet is held in the input register, decided by
// the single decision stage and captured in the result register. The state
// registers (session, last sequence, last timestamp, counters) are updated
// in the same cycle as the result register, so consecutive packets see each
// other's effect. Under rsp back-pressure the result register holds its beat
// and the input register can still take one more packet; after that
// req_chan.ready stays low until the waiting result beat is taken. The limits
// are written through the csr_ port at byte offsets 0 (position) and 4
// (speed) and should only change while no packet is in flight.
// ----------------------------------------------------------------------------
module vision_packet_acceptance_filter
   import vpaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   vpaf_req_if.sink              req_chan,
   vpaf_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   limits_type       limits;

   // input register stage
   logic             in_valid_ff, in_valid_in;
   req_beat_type     in_beat_ff, in_beat_in;

   // filter state
   filter_state_type state_ff, state_in;
   filter_state_type state_next;

   // result register stage
   logic             out_valid_ff, out_valid_in;
   rsp_beat_type     out_beat_ff, out_beat_in;
   rsp_beat_type     result;

   logic             advance;
   logic             req_take;

   vpaf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   vpaf_check u_check (
      .beat     (in_beat_ff),
      .state    (state_ff),
      .limits   (limits),
      .state_in (state_next),
      .result   (result)
   );

   // held beat moves to the result register when that register is free or
   // being drained this cycle
   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;

   always_comb begin
      in_beat_in.target_seen    = req_chan.target_seen;
      in_beat_in.measured_flag  = req_chan.measured_flag;
      in_beat_in.seq_number     = req_chan.seq_number;
      in_beat_in.source_time_ms = req_chan.source_time_ms;
      in_beat_in.ball_pos_mm    = req_chan.ball_pos_mm;
      in_beat_in.predicted_mm   = req_chan.predicted_mm;
      in_beat_in.ball_vel_mm_s  = req_chan.ball_vel_mm_s;

      in_valid_in  = req_take | (in_valid_ff & ~advance);
      out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);
      state_in     = advance ? state_next : state_ff;
      out_beat_in  = result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff <= in_beat_in;
      end
      if (advance) begin
         out_beat_ff <= out_beat_in;
      end
   end

   assign rsp_chan.valid                = out_valid_ff;
   assign rsp_chan.event_code           = out_beat_ff.event_code;
   assign rsp_chan.accepted             = out_beat_ff.accepted;
   assign rsp_chan.session_number       = out_beat_ff.session_number;
   assign rsp_chan.safe_predicted_mm    = out_beat_ff.safe_predicted_mm;
   assign rsp_chan.accepted_total       = out_beat_ff.counters[CNT_ACCEPTED];
   assign rsp_chan.target_total         = out_beat_ff.counters[CNT_TARGET];
   assign rsp_chan.no_target_total      = out_beat_ff.counters[CNT_NO_TARGET];
   assign rsp_chan.semantic_error_total = out_beat_ff.counters[CNT_SEMANTIC];
   assign rsp_chan.field_error_total    = out_beat_ff.counters[CNT_FIELD];
   assign rsp_chan.duplicate_total      = out_beat_ff.counters[CNT_DUPLICATE];
   assign rsp_chan.old_sequence_total   = out_beat_ff.counters[CNT_OLD];
   assign rsp_chan.session_change_total = out_beat_ff.counters[CNT_SESSION];

endmodule

// ----- rtl/vpaf_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpaf_csr
// APB-style register file holding the position and speed limits.
// ----------------------------------------------------------------------------
module vpaf_csr
   import vpaf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output limits_type            limits
);

   logic [15:0] position_limit_ff, position_limit_in;
   logic [15:0] speed_limit_ff, speed_limit_in;
   logic        write_en;
   logic        reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   // word index; byte offset bits are ignored
   assign reg_index  = csr_paddr[2];

   always_comb begin
      position_limit_in = position_limit_ff;
      speed_limit_in    = speed_limit_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_POSITION_LIMIT: position_limit_in = csr_pwdata[15:0];
            REG_SPEED_LIMIT:    speed_limit_in    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_POSITION_LIMIT: csr_prdata = {16'd0, position_limit_ff};
         REG_SPEED_LIMIT:    csr_prdata = {16'd0, speed_limit_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_limit_ff <= POSITION_LIMIT_RESET;
         speed_limit_ff    <= SPEED_LIMIT_RESET;
      end else begin
         position_limit_ff <= position_limit_in;
         speed_limit_ff    <= speed_limit_in;
      end
   end

   assign limits.position_limit_mm = position_limit_ff;
   assign limits.speed_limit_mm_s  = speed_limit_ff;

endmodule

// ----- rtl/vpaf_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpaf_check
// Acceptance decision for one packet beat and the resulting next state.
// ----------------------------------------------------------------------------
module vpaf_check
   import vpaf_pkg::*;
(
   input  req_beat_type     beat,
   input  filter_state_type state,
   input  limits_type       limits,
   output filter_state_type state_in,
   output rsp_beat_type     result
);

   logic [16:0]    pos_mag, vel_mag, pred_mag;
   logic [16:0]    pos_lim, speed_lim;
   logic [15:0]    seq_delta;
   logic           acc;
   logic           new_session;
   event_code_type ev;

   assign pos_mag   = mag16(beat.ball_pos_mm);
   assign vel_mag   = mag16(beat.ball_vel_mm_s);
   assign pred_mag  = mag16(beat.predicted_mm);
   assign pos_lim   = {1'b0, limits.position_limit_mm};
   assign speed_lim = {1'b0, limits.speed_limit_mm_s};
   assign seq_delta = beat.seq_number - state.last_seq;

   always_comb begin
      state_in    = state;
      acc         = 1'b0;
      new_session = 1'b0;
      ev          = EV_NEW_SESSION;

      if (beat.target_seen != beat.measured_flag) begin
         state_in.counters[CNT_SEMANTIC] = state.counters[CNT_SEMANTIC] + 32'd1;
         ev = EV_SEMANTIC;
      end else if (beat.target_seen && (pos_mag > pos_lim || vel_mag > speed_lim)) begin
         // flags agree here, so a target frame is also a measured frame
         state_in.counters[CNT_FIELD] = state.counters[CNT_FIELD] + 32'd1;
         ev = EV_FIELD;
      end else if (!state.session_started) begin
         state_in.cur_session = 32'd1;
         acc         = 1'b1;
         new_session = 1'b1;
      end else if (beat.source_time_ms < state.last_source_time) begin
         // sender restarted; id saturates
         if (state.cur_session != '1) begin
            state_in.cur_session = state.cur_session + 32'd1;
         end
         state_in.counters[CNT_SESSION] = state.counters[CNT_SESSION] + 32'd1;
         acc         = 1'b1;
         new_session = 1'b1;
      end else if (!state.sequence_started) begin
         acc = 1'b1;
      end else if (seq_delta == 16'd0) begin
         state_in.counters[CNT_DUPLICATE] = state.counters[CNT_DUPLICATE] + 32'd1;
         ev = EV_DUPLICATE;
      end else if (seq_delta[15]) begin
         state_in.counters[CNT_OLD] = state.counters[CNT_OLD] + 32'd1;
         ev = EV_OLD;
      end else begin
         acc = 1'b1;
      end

      result.safe_predicted_mm = 16'sd0;
      if (acc) begin
         result.safe_predicted_mm = (pred_mag > pos_lim) ? beat.ball_pos_mm
                                                         : beat.predicted_mm;
         state_in.session_started  = 1'b1;
         state_in.sequence_started = 1'b1;
         state_in.last_seq         = beat.seq_number;
         state_in.last_source_time = beat.source_time_ms;
         state_in.counters[CNT_ACCEPTED] = state.counters[CNT_ACCEPTED] + 32'd1;
         if (beat.target_seen) begin
            state_in.counters[CNT_TARGET] = state.counters[CNT_TARGET] + 32'd1;
         end else begin
            state_in.counters[CNT_NO_TARGET] = state.counters[CNT_NO_TARGET] + 32'd1;
         end
         if (new_session) begin
            ev = EV_NEW_SESSION;
         end else begin
            ev = beat.target_seen ? EV_TARGET : EV_NO_TARGET;
         end
      end

      result.event_code     = ev;
      result.accepted       = acc;
      result.session_number = state_in.cur_session;
      result.counters       = state_in.counters;
   end

endmodule
